// File: src/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared field widths, codes, state types and the controller/datapath links.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // Field widths of the request and response items.
   localparam int ACTION_W   = 2;
   localparam int TASK_ID_W  = 4;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Fewest tasks on the run list for a switch or a sleep.
   localparam int MIN_TO_SWITCH = 2;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SLEEP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd3;

   // Slot states.
   localparam logic [1:0] SLOT_EMPTY     = 2'd0;
   localparam logic [1:0] SLOT_SUSPENDED = 2'd1;
   localparam logic [1:0] SLOT_RUNNING   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_LISTED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LIST_FULL  = 2'd3;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_RUN_RD,
      S_RUN_WR,
      S_SLEEP_SCAN,
      S_TICK_ADV,
      S_POS_RD,
      S_CUR_LD,
      S_DONE
   } ctrl_state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_ACCEPT,
      DP_ALLOC_SCAN,
      DP_RUN_READ,
      DP_RUN_WRITE,
      DP_SLEEP_SCAN,
      DP_TICK_ADV,
      DP_POS_READ,
      DP_CUR_LOAD
   } dp_op_type;

   // Controller to datapath command.
   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic quick_done;
      logic alloc_hit;
      logic alloc_end;
      logic sleep_end;
      logic found;
      logic sleep_switch;
      logic out_free;
   } dp_stat_type;

endpackage

// File: src/rrts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task scheduler controller
// Sequences the datapath through one request at a time.
// ----------------------------------------------------------------------------
module rrts_ctrl
   import rrts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_tready,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.op       = DP_NONE;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = DP_ACCEPT;
               unique case (req_action)
                  ACT_ALLOC: state_in = S_ALLOC;
                  ACT_RUN:   state_in = stat.quick_done ? S_DONE : S_RUN_RD;
                  ACT_SLEEP: state_in = stat.quick_done ? S_DONE : S_SLEEP_SCAN;
                  ACT_TICK:  state_in = stat.quick_done ? S_DONE : S_TICK_ADV;
               endcase
            end
         end
         S_ALLOC: begin
            cmd.op = DP_ALLOC_SCAN;
            if (stat.alloc_hit || stat.alloc_end) begin
               state_in = S_DONE;
            end
         end
         S_RUN_RD: begin
            cmd.op   = DP_RUN_READ;
            state_in = S_RUN_WR;
         end
         S_RUN_WR: begin
            cmd.op   = DP_RUN_WRITE;
            state_in = S_DONE;
         end
         S_SLEEP_SCAN: begin
            cmd.op = DP_SLEEP_SCAN;
            if (stat.sleep_end) begin
               state_in = (stat.found && stat.sleep_switch) ? S_POS_RD : S_DONE;
            end
         end
         S_TICK_ADV: begin
            cmd.op   = DP_TICK_ADV;
            state_in = S_POS_RD;
         end
         S_POS_RD: begin
            cmd.op   = DP_POS_READ;
            state_in = S_CUR_LD;
         end
         S_CUR_LD: begin
            cmd.op   = DP_CUR_LOAD;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/rrts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task scheduler datapath
// Slot table, run list, counters, scan pipeline and the output register.
// ----------------------------------------------------------------------------
module rrts_dp
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [INDEX_W-1:0]   rsp_task_index,
   output logic                 rsp_do_switch,
   output logic [COUNT_W-1:0]   rsp_running_count
);

   localparam int SW   = $clog2(TASK_SLOTS);
   localparam int CNTW = $clog2(TASK_SLOTS + 1);
   localparam int EW   = (CNTW > TASK_ID_W) ? CNTW : TASK_ID_W;

   // Storage.
   logic [1:0]          slot_mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] slot_ok_ff;
   logic [SW-1:0]       list_mem [TASK_SLOTS];
   logic                list0_ok_ff;

   // Scheduler state.
   logic [CNTW-1:0]     run_count_ff;
   logic [SW-1:0]       pos_ff;
   logic [SW-1:0]       cur_task_ff;
   logic [TASK_ID_W-1:0] id_ff;

   // Scan pipeline.
   logic [CNTW-1:0]     scan_ff;
   logic                rd_vld_ff;
   logic [SW-1:0]       rd_idx_ff;
   logic [1:0]          slot_rd_ff;
   logic                slot_rd_ok_ff;
   logic [SW-1:0]       list_rd_ff;
   logic                list_rd_ok_ff;
   logic                found_ff;
   logic [SW-1:0]       fpos_ff;

   // Result staging and output register.
   logic [STATUS_W-1:0] res_status_ff;
   logic [INDEX_W-1:0]  res_index_ff;
   logic                res_switch_ff;
   logic                rsp_tvalid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_switch_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // Combinational signals.
   logic [EW-1:0]       id_ext;
   logic [SW-1:0]       id_slot;
   logic                req_oob;
   logic                rc_full;
   logic                rc_few;
   logic [1:0]          slot_eff;
   logic [SW-1:0]       list_eff;
   logic                match;
   logic                alloc_hit;
   logic                alloc_end;
   logic                sleep_end;
   logic                found_any;
   logic [SW-1:0]       fpos;
   logic                was_cur;
   logic [CNTW-1:0]     rc_dec;
   logic [SW-1:0]       pos_adj;
   logic [SW-1:0]       pos_fin;
   logic [CNTW-1:0]     pos_inc;
   logic [SW-1:0]       pos_tick;
   logic                quick_done;
   logic [STATUS_W-1:0] early_status;
   logic                accept;
   logic                slot_we;
   logic [SW-1:0]       slot_wa;
   logic [1:0]          slot_wd;
   logic                slot_re;
   logic [SW-1:0]       slot_ra;
   logic                list_we;
   logic [SW-1:0]       list_wa;
   logic [SW-1:0]       list_wd;
   logic                list_re;
   logic [SW-1:0]       list_ra;

   assign accept  = (cmd.op == DP_ACCEPT);
   assign id_ext  = EW'(id_ff);
   assign id_slot = id_ext[SW-1:0];
   assign req_oob = EW'(req_task_id) >= EW'(TASK_SLOTS);
   assign rc_full = run_count_ff >= CNTW'(TASK_SLOTS);
   assign rc_few  = run_count_ff < CNTW'(MIN_TO_SWITCH);

   // Read data with the reset contents standing in for unwritten entries.
   assign slot_eff = slot_rd_ok_ff ? slot_rd_ff :
                     ((rd_idx_ff == '0) ? SLOT_RUNNING : SLOT_EMPTY);
   assign list_eff = list_rd_ok_ff ? list_rd_ff : '0;

   // Scan decisions.
   assign match     = rd_vld_ff && (EW'(list_eff) == id_ext);
   assign alloc_hit = rd_vld_ff && (slot_eff == SLOT_EMPTY);
   assign alloc_end = rd_vld_ff && (rd_idx_ff == SW'(TASK_SLOTS - 1));
   assign sleep_end = rd_vld_ff && (CNTW'(rd_idx_ff) == run_count_ff - CNTW'(1));
   assign found_any = found_ff || match;
   assign fpos      = found_ff ? fpos_ff : rd_idx_ff;
   assign was_cur   = (fpos == pos_ff);

   // Position after a sleep: shift down past the removed entry, wrap at the end.
   assign rc_dec  = run_count_ff - CNTW'(1);
   assign pos_adj = (fpos < pos_ff) ? (pos_ff - SW'(1)) : pos_ff;
   assign pos_fin = (was_cur && (CNTW'(pos_adj) >= rc_dec)) ? '0 : pos_adj;

   // Position after a tick.
   assign pos_inc  = CNTW'(pos_ff) + CNTW'(1);
   assign pos_tick = (pos_inc >= run_count_ff) ? '0 : pos_inc[SW-1:0];

   // Requests that finish without touching the tables.
   always_comb begin
      quick_done   = 1'b0;
      early_status = ST_OK;
      unique case (req_action)
         ACT_ALLOC: begin
            early_status = ST_NO_SLOT;
         end
         ACT_RUN: begin
            quick_done = rc_full || req_oob;
            if (rc_full) begin
               early_status = ST_LIST_FULL;
            end else if (req_oob) begin
               early_status = ST_NOT_LISTED;
            end
         end
         ACT_SLEEP: begin
            quick_done = rc_few;
            if (rc_few) begin
               early_status = ST_NOT_LISTED;
            end
         end
         ACT_TICK: begin
            quick_done = rc_few;
         end
      endcase
   end

   // Memory port control.
   always_comb begin
      slot_we = 1'b0;
      slot_wa = rd_idx_ff;
      slot_wd = SLOT_SUSPENDED;
      slot_re = 1'b0;
      slot_ra = scan_ff[SW-1:0];
      list_we = 1'b0;
      list_wa = rd_idx_ff - SW'(1);
      list_wd = list_eff;
      list_re = 1'b0;
      list_ra = scan_ff[SW-1:0];
      unique case (cmd.op)
         DP_ALLOC_SCAN: begin
            slot_re = scan_ff < CNTW'(TASK_SLOTS);
            slot_we = alloc_hit;
         end
         DP_RUN_READ: begin
            slot_re = 1'b1;
            slot_ra = id_slot;
         end
         DP_RUN_WRITE: begin
            if (slot_eff != SLOT_RUNNING) begin
               slot_we = 1'b1;
               slot_wa = id_slot;
               slot_wd = SLOT_RUNNING;
               list_we = 1'b1;
               list_wa = run_count_ff[SW-1:0];
               list_wd = id_slot;
            end
         end
         DP_SLEEP_SCAN: begin
            // Entries behind the match move down by one as they stream past.
            list_re = scan_ff < run_count_ff;
            list_we = rd_vld_ff && found_ff;
            slot_we = sleep_end && found_any;
            slot_wa = id_slot;
         end
         DP_POS_READ: begin
            list_re = 1'b1;
            list_ra = pos_ff;
         end
         DP_NONE, DP_ACCEPT, DP_TICK_ADV, DP_CUR_LOAD: begin
         end
         default: begin
         end
      endcase
   end

   // Slot table.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_ra];
      end
   end

   // Run list.
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      if (list_re) begin
         list_rd_ff <= list_mem[list_ra];
      end
   end

   // Written flags for the tables and the read pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ok_ff  <= '0;
         list0_ok_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (slot_we) begin
            slot_ok_ff[slot_wa] <= 1'b1;
         end
         if (list_we && (list_wa == '0)) begin
            list0_ok_ff <= 1'b1;
         end
         rd_vld_ff <= !accept && (slot_re || list_re);
      end
   end

   always_ff @(posedge clock) begin
      if (slot_re) begin
         rd_idx_ff     <= slot_ra;
         slot_rd_ok_ff <= slot_ok_ff[slot_ra];
      end else if (list_re) begin
         rd_idx_ff     <= list_ra;
         list_rd_ok_ff <= (list_ra != '0) || list0_ok_ff;
      end
   end

   // Scan address and search result.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (slot_re || list_re) begin
            scan_ff <= scan_ff + CNTW'(1);
         end
         if ((cmd.op == DP_SLEEP_SCAN) && match && !found_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == DP_SLEEP_SCAN) && match && !found_ff) begin
         fpos_ff <= rd_idx_ff;
      end
      if (accept) begin
         id_ff <= req_task_id;
      end
   end

   // Run count, current position and current task.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= CNTW'(1);
         pos_ff       <= '0;
         cur_task_ff  <= '0;
      end else begin
         if ((cmd.op == DP_RUN_WRITE) && (slot_eff != SLOT_RUNNING)) begin
            run_count_ff <= run_count_ff + CNTW'(1);
         end
         if ((cmd.op == DP_SLEEP_SCAN) && sleep_end && found_any) begin
            run_count_ff <= rc_dec;
            pos_ff       <= pos_fin;
         end
         if (cmd.op == DP_TICK_ADV) begin
            pos_ff <= pos_tick;
         end
         if (cmd.op == DP_CUR_LOAD) begin
            cur_task_ff <= list_eff;
         end
      end
   end

   // Result staging.
   always_ff @(posedge clock) begin
      if (accept) begin
         res_status_ff <= early_status;
         res_index_ff  <= (req_action == ACT_ALLOC) ? '0 : INDEX_W'(cur_task_ff);
         res_switch_ff <= 1'b0;
      end else if ((cmd.op == DP_ALLOC_SCAN) && alloc_hit) begin
         res_status_ff <= ST_OK;
         res_index_ff  <= INDEX_W'(rd_idx_ff);
      end else if ((cmd.op == DP_SLEEP_SCAN) && sleep_end && !found_any) begin
         res_status_ff <= ST_NOT_LISTED;
      end else if (cmd.op == DP_CUR_LOAD) begin
         res_index_ff  <= INDEX_W'(list_eff);
         res_switch_ff <= 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_switch_ff <= res_switch_ff;
         rsp_count_ff  <= COUNT_W'(run_count_ff);
      end
   end

   assign rsp_tvalid        = rsp_tvalid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_task_index    = rsp_index_ff;
   assign rsp_do_switch     = rsp_switch_ff;
   assign rsp_running_count = rsp_count_ff;

   // Status back to the controller.
   assign stat.quick_done   = quick_done;
   assign stat.alloc_hit    = alloc_hit;
   assign stat.alloc_end    = alloc_end;
   assign stat.sleep_end    = sleep_end;
   assign stat.found        = found_any;
   assign stat.sleep_switch = was_cur;
   assign stat.out_free     = !rsp_tvalid_ff || rsp_tready;

endmodule

// File: src/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
// Allocation scans for a free slot, one slot table read per cycle. A run reads, then writes
// the slot table. A switching tick advances the position, reads the run list and loads the
// current task. A sleep searches and compacts the run list through its port, and reads and
// loads the new current task if it slept. Quick rejects and non-switching ticks skip that.
// One request is in work at a time; the next is taken the cycle after the result is stored.
// Reset is synchronous: slot 0 running and current, run count 1; no clearing pass.
// ----------------------------------------------------------------------------
// Round-robin task scheduler core
// Slot allocation, run list upkeep and timeslice switching over stream ports.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // action[1:0], task_id[5:2], zero[7:6]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], task_index[5:2],
                                             // do_switch[6], running_count[11:7],
                                             // zero[15:12]
);

   dp_cmd_type           cmd;
   dp_stat_type          stat;
   logic [ACTION_W-1:0]  req_action;
   logic [TASK_ID_W-1:0] req_task_id;
   logic [STATUS_W-1:0]  rsp_status;
   logic [INDEX_W-1:0]   rsp_task_index;
   logic                 rsp_do_switch;
   logic [COUNT_W-1:0]   rsp_running_count;

   // Request fields.
   assign req_action  = req_tdata[ACTION_W-1:0];
   assign req_task_id = req_tdata[ACTION_W+TASK_ID_W-1:ACTION_W];

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_action),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rrts_dp #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_task_id       (req_task_id),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_status        (rsp_status),
      .rsp_task_index    (rsp_task_index),
      .rsp_do_switch     (rsp_do_switch),
      .rsp_running_count (rsp_running_count)
   );

   // Response packing.
   assign rsp_tdata = {4'b0000, rsp_running_count, rsp_do_switch, rsp_task_index, rsp_status};

`ifndef SYNTH
   // A transfer starts work, so the request side closes on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request side still open after a transfer");

   // A switch only comes with a successful step.
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[1:0] == ST_OK)
      else $error("switch reported with a failing status");

   // A failed allocation reports slot zero.
   a_no_slot_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_NO_SLOT) |-> rsp_tdata[5:2] == 4'd0)
      else $error("failed allocation with a nonzero slot");

   // The output register is loaded only when its previous result is gone.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten before transfer");
`endif

endmodule

// File: tb/sv/round_robin_task_scheduler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task scheduler core testbench
// Drives scheduler requests over the request stream and checks every response
// against a cycle-free model of the slot table, run list and current position.
// A short scripted opening covers reset state, error codes and list edge cases.
// Random sequences follow: list fills and drains, allocation bursts, mixed
// traffic and noise, with random stalls on both streams.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core_test;
   import rrts_pkg::*;

   localparam int TASK_SLOTS   = 16;
   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 40;
   localparam int HOLD_CYCLES  = 300;

   // One response item as the block packs it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  task_index;
      logic                do_switch;
      logic [COUNT_W-1:0]  running_count;
   } sched_result_t;

   // One scripted request; the response is typed in only when typed is set.
   typedef struct packed {
      logic [ACTION_W-1:0]  act;
      logic [TASK_ID_W-1:0] id;
      logic                 typed;
      sched_result_t        want;
   } script_row_t;

   localparam int SCRIPT_LEN = 24;
   localparam script_row_t OPENING_SCRIPT [0:SCRIPT_LEN-1] = '{
      // Reset state: a tick with one task does not switch.
      '{ACT_TICK,  4'd0,  1'b1, '{ST_OK,         4'd0, 1'b0, 5'd1}},
      // The last task on the list cannot sleep.
      '{ACT_SLEEP, 4'd0,  1'b1, '{ST_NOT_LISTED, 4'd0, 1'b0, 5'd1}},
      // A task that is not on the list cannot sleep.
      '{ACT_SLEEP, 4'd9,  1'b1, '{ST_NOT_LISTED, 4'd0, 1'b0, 5'd1}},
      // Running a task that already runs changes nothing.
      '{ACT_RUN,   4'd0,  1'b1, '{ST_OK,         4'd0, 1'b0, 5'd1}},
      // Allocation takes the lowest empty slots.
      '{ACT_ALLOC, 4'd0,  1'b1, '{ST_OK,         4'd1, 1'b0, 5'd1}},
      '{ACT_ALLOC, 4'd0,  1'b1, '{ST_OK,         4'd2, 1'b0, 5'd1}},
      // A suspended slot, an empty slot and another suspended slot join the list.
      '{ACT_RUN,   4'd1,  1'b0, '0},
      '{ACT_RUN,   4'd15, 1'b0, '0},
      '{ACT_RUN,   4'd2,  1'b0, '0},
      // A full round of ticks, wrapping back to the head of the list.
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_TICK,  4'd0,  1'b0, '0},
      // Sleep ahead of the current position, then behind it.
      '{ACT_SLEEP, 4'd15, 1'b0, '0},
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_SLEEP, 4'd0,  1'b0, '0},
      // The current task at the tail sleeps: the position wraps to the head.
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_SLEEP, 4'd2,  1'b0, '0},
      '{ACT_SLEEP, 4'd1,  1'b0, '0},
      '{ACT_RUN,   4'd0,  1'b0, '0},
      '{ACT_RUN,   4'd10, 1'b0, '0},
      '{ACT_RUN,   4'd5,  1'b0, '0},
      // The current task in mid list sleeps: the next one takes its place.
      '{ACT_TICK,  4'd0,  1'b0, '0},
      '{ACT_SLEEP, 4'd0,  1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Scheduler model state.
   logic [1:0]           slot_tab [TASK_SLOTS];
   logic [TASK_ID_W-1:0] run_order [TASK_SLOTS];
   int                   run_total;
   int                   cur_pos;

   sched_result_t pending_results [$];
   int            error_count;
   int            sent_count;
   int            cycle_count;
   int            action_seen [4];
   int            status_seen [4];
   int            switch_seen;
   bit            quiet;
   bit            hold_rsp_req;

   round_robin_task_scheduler_core #(
      .TASK_SLOTS(TASK_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // Applies one action to the model and returns the response it must produce.
   function automatic sched_result_t apply_sched_action(input logic [ACTION_W-1:0] act,
                                                        input logic [TASK_ID_W-1:0] id);
      sched_result_t r;
      int            pos;
      bit            hit;
      bit            was_cur;
      r = '0;
      case (act)
         ACT_ALLOC: begin
            r.status = ST_NO_SLOT;
            hit = 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (!hit && slot_tab[i] == SLOT_EMPTY) begin
                  slot_tab[i] = SLOT_SUSPENDED;
                  r.task_index = i[INDEX_W-1:0];
                  r.status = ST_OK;
                  hit = 1'b1;
               end
            end
         end
         ACT_RUN: begin
            // A four-bit id always names a slot, so only the full list is refused.
            if (run_total >= TASK_SLOTS) begin
               r.status = ST_LIST_FULL;
            end else if (slot_tab[id] != SLOT_RUNNING) begin
               slot_tab[id] = SLOT_RUNNING;
               run_order[run_total] = id;
               run_total++;
            end
         end
         ACT_SLEEP: begin
            pos = run_total;
            for (int i = 0; i < run_total; i++) begin
               if (pos == run_total && run_order[i] == id) begin
                  pos = i;
               end
            end
            if (pos >= run_total || run_total < MIN_TO_SWITCH) begin
               r.status = ST_NOT_LISTED;
            end else begin
               was_cur = (pos == cur_pos);
               run_total--;
               if (pos < cur_pos) begin
                  cur_pos--;
               end
               for (int i = pos; i < run_total; i++) begin
                  run_order[i] = run_order[i + 1];
               end
               slot_tab[id] = SLOT_SUSPENDED;
               if (was_cur) begin
                  if (cur_pos >= run_total) begin
                     cur_pos = 0;
                  end
                  r.do_switch = 1'b1;
               end
            end
         end
         default: begin
            if (run_total >= MIN_TO_SWITCH) begin
               cur_pos++;
               if (cur_pos >= run_total) begin
                  cur_pos = 0;
               end
               r.do_switch = 1'b1;
            end
         end
      endcase
      // Every action but allocation reports the task that is current afterwards.
      if (act != ACT_ALLOC && cur_pos < run_total) begin
         r.task_index = run_order[cur_pos];
      end
      r.running_count = run_total[COUNT_W-1:0];
      return r;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   // Offers one request, waits for its transfer and records what it must return.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TASK_ID_W-1:0] id,
                            input logic typed, input sched_result_t want);
      sched_result_t predicted;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, id, act};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = apply_sched_action(act, id);
      pending_results.push_back(typed ? want : predicted);
      action_seen[act]++;
      sent_count++;
   endtask

   // Response side: random stalls, a quiet stretch and one long hold-off.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 15);
         end
      end
   end

   // Checks each response transfer against the oldest pending result.
   always @(posedge clock) begin
      sched_result_t got;
      sched_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = rsp_tdata[1:0];
         got.task_index    = rsp_tdata[5:2];
         got.do_switch     = rsp_tdata[6];
         got.running_count = rsp_tdata[11:7];
         status_seen[got.status]++;
         if (got.do_switch) begin
            switch_seen++;
         end
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response 0x%h with no request outstanding", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.task_index !== want.task_index) begin
               report_mismatch($sformatf("task_index %0d, expected %0d",
                                         got.task_index, want.task_index));
            end
            if (got.do_switch !== want.do_switch) begin
               report_mismatch($sformatf("do_switch %0d, expected %0d",
                                         got.do_switch, want.do_switch));
            end
            if (got.running_count !== want.running_count) begin
               report_mismatch($sformatf("running_count %0d, expected %0d",
                                         got.running_count, want.running_count));
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("round_robin_task_scheduler_core_test failed");
         $finish;
      end
   end

   // Main stimulus.
   initial begin
      int                   kind;
      int                   len;
      int                   j;
      int                   random_sent;
      int                   roll;
      bit                   hold_done;
      bit                   drain_done;
      bit                   first_seq;
      logic [TASK_ID_W-1:0] shuffle [TASK_SLOTS];
      logic [TASK_ID_W-1:0] tmp;
      logic [ACTION_W-1:0]  act;
      logic [TASK_ID_W-1:0] id;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      quiet = 1'b0;
      hold_rsp_req = 1'b0;
      error_count = 0;
      sent_count = 0;
      cycle_count = 0;
      switch_seen = 0;
      for (int i = 0; i < 4; i++) begin
         action_seen[i] = 0;
         status_seen[i] = 0;
      end

      // Model after reset: slot 0 running and current, alone on the list.
      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_tab[i] = SLOT_EMPTY;
         run_order[i] = '0;
      end
      slot_tab[0] = SLOT_RUNNING;
      run_total = 1;
      cur_pos = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scripted opening.
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_item(OPENING_SCRIPT[i].act, OPENING_SCRIPT[i].id,
                   OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].want);
      end

      // Random sequences; the first one fills and drains the run list.
      hold_done = 1'b0;
      drain_done = 1'b0;
      first_seq = 1'b1;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         quiet = (random_sent >= 150 && random_sent < 300);
         if (!hold_done && random_sent >= 400) begin
            hold_rsp_req = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && random_sent >= 600) begin
            // Withdraw the request so the block does not take it a second time.
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) begin
               @(posedge clock);
            end
            drain_done = 1'b1;
         end
         kind = first_seq ? 0 : $urandom_range(99);
         first_seq = 1'b0;
         if (kind < 10) begin
            // Put every slot on the list, overrun it, then sleep down past the last task.
            for (int i = 0; i < TASK_SLOTS; i++) begin
               shuffle[i] = i[TASK_ID_W-1:0];
            end
            for (int i = TASK_SLOTS - 1; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = shuffle[i];
               shuffle[i] = shuffle[j];
               shuffle[j] = tmp;
            end
            for (int i = 0; i < TASK_SLOTS; i++) begin
               send_item(ACT_RUN, shuffle[i], 1'b0, '0);
            end
            len = $urandom_range(3, 1);
            for (int i = 0; i < len; i++) begin
               send_item(ACT_RUN, 4'($urandom_range(15)), 1'b0, '0);
            end
            while (run_total > 1) begin
               send_item(ACT_SLEEP, run_order[$urandom_range(run_total - 1)], 1'b0, '0);
               if ($urandom_range(3) == 0) begin
                  send_item(ACT_TICK, 4'($urandom_range(15)), 1'b0, '0);
               end
            end
            send_item(ACT_SLEEP, run_order[0], 1'b0, '0);
            random_sent += 2 * TASK_SLOTS + len;
         end else if (kind < 20) begin
            // Allocation burst.
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
               send_item(ACT_ALLOC, 4'($urandom_range(15)), 1'b0, '0);
            end
            random_sent += len;
         end else if (kind < 30) begin
            // Noise: any action with any id.
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) begin
               send_item(2'($urandom_range(3)), 4'($urandom_range(15)), 1'b0, '0);
            end
            random_sent += len;
         end else begin
            // Mixed traffic with sleeps aimed mostly at listed tasks.
            len = $urandom_range(20, 8);
            for (int i = 0; i < len; i++) begin
               roll = $urandom_range(99);
               id = 4'($urandom_range(15));
               if (roll < 35) begin
                  act = ACT_TICK;
               end else if (roll < 60) begin
                  act = ACT_RUN;
               end else if (roll < 90) begin
                  act = ACT_SLEEP;
                  roll = $urandom_range(9);
                  if (roll < 3) begin
                     id = run_order[cur_pos];
                  end else if (roll < 8) begin
                     id = run_order[$urandom_range(run_total - 1)];
                  end
               end else begin
                  act = ACT_ALLOC;
               end
               send_item(act, id, 1'b0, '0);
            end
            random_sent += len;
         end
      end
      quiet = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Let every outstanding response arrive, then allow for stray ones.
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d requests: %0d allocate, %0d run, %0d sleep, %0d tick.",
               sent_count, action_seen[ACT_ALLOC], action_seen[ACT_RUN],
               action_seen[ACT_SLEEP], action_seen[ACT_TICK]);
      $display("Responses: %0d ok, %0d no free slot, %0d not listed, %0d list full, %0d switches.",
               status_seen[ST_OK], status_seen[ST_NO_SLOT], status_seen[ST_NOT_LISTED],
               status_seen[ST_LIST_FULL], switch_seen);
      if (error_count == 0) begin
         $display("round_robin_task_scheduler_core_test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("round_robin_task_scheduler_core_test failed");
      end
      $finish;
   end

endmodule
